/* rtl/urd_pkg.sv */
package urd_pkg;

    localparam int VALUE_BITS  = 64;
    localparam int STEP_BITS   = 8;
    localparam int DIV_STEPS   = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_BITS    = DIV_STEPS * STEP_BITS;
    localparam int DIV_CNT_W   = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam int DIGIT_SLOTS = 64;
    localparam int ADDR_W      = $clog2(DIGIT_SLOTS);
    localparam int COUNT_W     = 7;
    localparam int DIGIT_W     = 4;
    localparam int BASE_W      = 5;
    localparam int CHAR_W      = 7;
    localparam int RADIX_W     = 8;
    localparam int IN_VALUE_W  = 64;

    localparam logic [BASE_W-1:0] DEFAULT_BASE = BASE_W'(10);
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [DIGIT_W-1:0] data;
    } t_store_wr;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DIVIDE = 4'b0010,
        S_FETCH  = 4'b0100,
        S_SHOW   = 4'b1000
    } t_state;

    function automatic logic [BASE_W-1:0] map_base(input logic [RADIX_W-1:0] radix);
        logic [BASE_W-1:0] result;
        if (radix < RADIX_W'(2) || radix > RADIX_W'(16)) begin
            result = DEFAULT_BASE;
        end else begin
            result = radix[BASE_W-1:0];
        end
        return result;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d,
                                                      input logic upper);
        logic [CHAR_W-1:0] result;
        if (d < DIGIT_W'(10)) begin
            result = CHAR_ZERO + CHAR_W'(d);
        end else if (upper) begin
            result = CHAR_UPPER_A + CHAR_W'(d) - CHAR_W'(10);
        end else begin
            result = CHAR_LOWER_A + CHAR_W'(d) - CHAR_W'(10);
        end
        return result;
    endfunction

endpackage

/* rtl/urd_divider.sv */
module urd_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [urd_pkg::VALUE_BITS-1:0] i_dividend,
    input  logic [urd_pkg::BASE_W-1:0]     i_base,
    output logic                          o_done,
    output logic [urd_pkg::VALUE_BITS-1:0] o_quotient,
    output logic [urd_pkg::DIGIT_W-1:0]    o_remainder
);
    import urd_pkg::*;

    logic [PAD_BITS-1:0]  r_work;
    logic [PAD_BITS-1:0]  n_work;
    logic [DIGIT_W-1:0]   r_rem;
    logic [DIGIT_W-1:0]   n_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    // Restoring division, several quotient bits per cycle; the remainder
    // stays below the base, so it is at most four bits wide.
    always_comb begin
        logic [DIGIT_W:0]     t;
        logic [DIGIT_W-1:0]   rem;
        logic [STEP_BITS-1:0] q;
        rem = r_rem;
        q   = '0;
        for (int j = 0; j < STEP_BITS; j++) begin
            t = {rem, r_work[PAD_BITS-1-j]};
            if (t >= i_base) begin
                q[STEP_BITS-1-j] = 1'b1;
                t = t - i_base;
            end
            rem = t[DIGIT_W-1:0];
        end
        n_rem  = rem;
        n_work = (r_work << STEP_BITS) | PAD_BITS'(q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_work <= PAD_BITS'(i_dividend);
            r_rem  <= '0;
        end else if (r_busy) begin
            r_work <= n_work;
            r_rem  <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_work[VALUE_BITS-1:0];
    assign o_remainder = r_rem;

endmodule

/* rtl/urd_digit_store.sv */
module urd_digit_store (
    input  logic                        i_clk,
    input  urd_pkg::t_store_wr          i_wr,
    input  logic [urd_pkg::ADDR_W-1:0]  i_rd_addr,
    output logic [urd_pkg::DIGIT_W-1:0] o_rd_data
);
    import urd_pkg::*;

    logic [DIGIT_W-1:0] r_mem [DIGIT_SLOTS];
    logic [DIGIT_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/unsigned_to_radix_digits.sv */
// Channel   Direction  Handshake                  Payload
// request   in         start high, busy low       i_value, i_radix, i_upper_case
// digit     out        o_valid for one cycle      o_digit_char, o_last_digit, o_digit_count
//
// A request is loaded into the shared divider, which yields one digit per division
// and writes it to the digit store; the store is then read back, most significant
// digit first, and each digit presented. A zero value skips the divider.
// Reset is synchronous and active low; the block comes out of it idle.
// Digits cannot be held off by the receiver; busy stays high until the last one.
module unsigned_to_radix_digits (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [urd_pkg::IN_VALUE_W-1:0] i_value,
    input  logic [urd_pkg::RADIX_W-1:0]    i_radix,
    input  logic                           i_upper_case,
    output logic                           o_valid,
    output logic [urd_pkg::CHAR_W-1:0]     o_digit_char,
    output logic                           o_last_digit,
    output logic [urd_pkg::COUNT_W-1:0]    o_digit_count
);
    import urd_pkg::*;

    t_state               r_state;
    t_state               n_state;
    logic [COUNT_W-1:0]   r_count;
    logic [COUNT_W-1:0]   n_count;
    logic [ADDR_W-1:0]    r_idx;
    logic [ADDR_W-1:0]    n_idx;
    logic [BASE_W-1:0]    r_base;
    logic                 r_upper;
    logic                 accept;
    logic [VALUE_BITS-1:0] masked_value;

    logic                  div_load;
    logic [VALUE_BITS-1:0] div_dividend;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quotient;
    logic [DIGIT_W-1:0]    div_remainder;

    t_store_wr             store_wr;
    logic [DIGIT_W-1:0]    rd_data;

    assign accept       = start && !busy;
    assign masked_value = i_value[VALUE_BITS-1:0];

    urd_divider u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (div_load),
        .i_dividend  (div_dividend),
        .i_base      (r_base),
        .o_done      (div_done),
        .o_quotient  (div_quotient),
        .o_remainder (div_remainder)
    );

    urd_digit_store u_store (
        .i_clk     (i_clk),
        .i_wr      (store_wr),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_idx         = r_idx;
        div_load      = 1'b0;
        div_dividend  = div_quotient;
        store_wr.en   = 1'b0;
        store_wr.addr = r_count[ADDR_W-1:0];
        store_wr.data = div_remainder;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (masked_value == '0) begin
                        store_wr.en   = 1'b1;
                        store_wr.addr = '0;
                        store_wr.data = '0;
                        n_count       = COUNT_W'(1);
                        n_idx         = '0;
                        n_state       = S_FETCH;
                    end else begin
                        div_load     = 1'b1;
                        div_dividend = masked_value;
                        n_count      = '0;
                        n_state      = S_DIVIDE;
                    end
                end
            end
            S_DIVIDE: begin
                if (div_done) begin
                    store_wr.en = 1'b1;
                    n_count     = r_count + COUNT_W'(1);
                    n_idx       = r_count[ADDR_W-1:0];
                    if (div_quotient == '0 || n_count == COUNT_W'(DIGIT_SLOTS)) begin
                        n_state = S_FETCH;
                    end else begin
                        div_load = 1'b1;
                    end
                end
            end
            S_FETCH: begin
                n_state = S_SHOW;
            end
            S_SHOW: begin
                if (r_idx == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx   = r_idx - ADDR_W'(1);
                    n_state = S_FETCH;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (accept) begin
            r_base  <= map_base(i_radix);
            r_upper <= i_upper_case;
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_SHOW);
    assign o_last_digit  = o_valid && (r_idx == '0);
    assign o_digit_char  = digit_ascii(rd_data, r_upper);
    assign o_digit_count = o_last_digit ? r_count : '0;

    a_valid_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("digit presented while idle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("request taken but block not busy");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_digit |=> !busy)
        else $error("block still busy after the last digit");

    a_count_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_digit) |-> (o_digit_count == '0))
        else $error("digit count given on a digit that is not the last");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_digit |-> (o_digit_count != '0))
        else $error("last digit carries a zero count");

endmodule
